[rtl/core/pllm_pkg.sv]
// Package for the pooled linked-list manager: command and status codes and the controller states.
// It has no dependencies. The pooled_linked_list_manager_core module imports it.
`timescale 1ns / 1ps
package pllm_pkg;
	localparam int CMD_W = 3;
	localparam logic [2:0] CMD_ALLOC  = 3'd0;
	localparam logic [2:0] CMD_FREE   = 3'd1;
	localparam logic [2:0] CMD_SEARCH = 3'd2;
	localparam logic [2:0] CMD_KILL   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FAIL    = 2'd1;
	localparam logic [1:0] ST_UNUSED  = 2'd2;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_ALLOC, S_APATCH, S_FREE, S_REL, S_PWR, S_NRD, S_NWR,
		S_CLR, S_WALK, S_WALKRD, S_OUT
	} state_t;
endpackage

[rtl/core/pllm_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// It has no dependencies.
`timescale 1ns / 1ps
module pllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[rtl/core/pooled_linked_list_manager_core.sv]
// Top level of the pooled linked-list manager: the command controller and the entry and stack memories.
// It depends on pllm_pkg and pllm_ram.
//
//  channel | direction | tdata fields (lowest bit first)
//  s_axis  | in        | command, list_sel, slot, effect_id, match_all (from_tail on tuser)
//  m_axis  | out       | status, found_slot, free_count, low_water
//
// After reset, a clearing pass initializes the memories, and no command is taken during it.
// A rejected command goes from S_RD straight to S_OUT. An allocate passes S_ALLOC, and S_APATCH
// as well when it links behind an existing tail; a free passes S_FREE and, unless it is refused,
// S_REL, S_PWR, S_NRD, S_NWR and S_CLR. Search, kill and clear pass S_WALK and S_WALKRD for each
// entry visited, and clear also runs S_REL to S_CLR for each entry it unlinks.
// One command is handled at a time; a finished result waits in S_OUT while the output register
// still holds an unread result, and s_axis_tready is high only in S_IDLE.
module pooled_linked_list_manager_core #(
	parameter int POOL_SIZE  = 256,
	parameter int LIST_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // command[2:0] list_sel[5:3] slot[13:6] effect_id[22:14] match_all[23]
	input  logic        s_axis_tuser,  // from_tail
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // status[1:0] found_slot[9:2] free_count[18:10] low_water[27:19]
);
	import pllm_pkg::*;
	localparam int AW = $clog2(POOL_SIZE);
	localparam int PW = AW + 1;   // link width: null is POOL_SIZE
	localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
	localparam logic [PW-1:0] NIL = PW'(POOL_SIZE);
	localparam int EW = 2 * PW + LW + 9 + 2;   // next, prev, owner, id, dead, in_use

	typedef struct packed {
		logic [PW-1:0] nxt;
		logic [PW-1:0] prv;
		logic [LW-1:0] own;
		logic [8:0]    id;
		logic          dead;
		logic          used;
	} entry_t;

	state_t        state_q, state_d;
	logic [2:0]    cmd_q;
	logic [2:0]    lst_q;
	logic [7:0]    slot_q;
	logic [8:0]    id_q;
	logic          all_q, back_q;
	logic [PW-1:0] top_q, least_q;
	logic [PW-1:0] head_q [LIST_COUNT];
	logic [PW-1:0] tail_q [LIST_COUNT];
	logic [AW-1:0] init_q;
	logic [PW-1:0] cur_q, guard_q;
	entry_t        ent_q;      // image of the entry being unlinked or of the old tail
	logic [AW-1:0] q_q;        // slot popped by an allocate
	logic [1:0]    stat_q;
	logic [7:0]    found_q;
	logic          ovalid_q;
	logic [31:0]   out_q;

	logic          e_we, f_we;
	logic [AW-1:0] e_addr, f_addr;
	entry_t        e_wd, e_rd;
	logic [AW-1:0] f_wd, f_rd;
	logic [EW-1:0] e_rdv;

	logic          list_ok, in_acc, slot_ok, out_go, hit;
	logic [LW-1:0] li;
	logic [LW-1:0] own_safe;

	pllm_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_entry (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wd), .rdata(e_rdv)
	);
	assign e_rd = entry_t'(e_rdv);
	pllm_ram #(.WIDTH(AW), .DEPTH(POOL_SIZE)) u_stack (
		.clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd)
	);

	assign list_ok = 32'(lst_q) < LIST_COUNT;
	assign slot_ok = 32'(slot_q) < POOL_SIZE;
	assign li      = LW'(lst_q);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_go  = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = out_q;

	// The current entry matches when the whole list is selected or its id is the one given.
	assign hit = all_q || (e_rd.id == id_q);
	assign own_safe = (32'(ent_q.own) < LIST_COUNT) ? ent_q.own : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT:   if (32'(init_q) == POOL_SIZE - 1) state_d = S_IDLE;
			S_IDLE:   if (in_acc) state_d = S_RD;
			S_RD: begin
				case (cmd_q)
					CMD_ALLOC:  state_d = (list_ok && top_q != '0) ? S_ALLOC : S_OUT;
					CMD_FREE:   state_d = S_FREE;
					CMD_SEARCH, CMD_KILL, CMD_CLEAR:
						state_d = list_ok ? S_WALK : S_OUT;
					default:    state_d = S_OUT;
				endcase
			end
			S_ALLOC:  state_d = (cur_q == NIL) ? S_OUT : S_APATCH;
			S_APATCH: state_d = S_OUT;
			S_FREE:   state_d = (slot_ok && e_rd.used) ? S_REL : S_OUT;
			S_REL:    state_d = S_PWR;
			S_PWR:    state_d = S_NRD;
			S_NRD:    state_d = S_NWR;
			S_NWR:    state_d = S_CLR;
			S_CLR:    state_d = (cmd_q == CMD_CLEAR) ? S_WALK : S_OUT;
			S_WALK:   state_d = (cur_q == NIL || guard_q == NIL) ? S_OUT : S_WALKRD;
			S_WALKRD: begin
				if (cmd_q == CMD_SEARCH && e_rd.id == id_q) state_d = S_OUT;
				else if (cmd_q == CMD_CLEAR && hit) state_d = S_REL;
				else state_d = S_WALK;
			end
			S_OUT:    if (out_go) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory ports
	always_comb begin
		e_we = 1'b0; e_addr = '0; e_wd = '0;
		f_we = 1'b0; f_addr = '0; f_wd = '0;
		case (state_q)
			S_INIT: begin
				e_we = 1'b1; e_addr = init_q;
				e_wd.nxt = NIL; e_wd.prv = NIL;
				f_we = 1'b1; f_addr = init_q;
				f_wd = AW'(POOL_SIZE - 1) - init_q;
			end
			S_RD: begin
				f_addr = AW'(top_q - PW'(1));
				e_addr = (cmd_q == CMD_FREE) ? AW'(slot_q) : AW'(tail_q[li]);
			end
			S_ALLOC: begin
				e_we = 1'b1; e_addr = f_rd;
				e_wd.nxt = NIL; e_wd.prv = cur_q;
				e_wd.own = li; e_wd.id = id_q; e_wd.used = 1'b1;
			end
			S_APATCH: begin
				// The old tail now points forward to the new entry.
				e_we = 1'b1; e_addr = AW'(cur_q);
				e_wd = ent_q; e_wd.nxt = PW'(q_q);
			end
			S_REL: begin
				e_addr = AW'(ent_q.prv);
				f_we = (top_q < NIL); f_addr = AW'(top_q); f_wd = AW'(cur_q);
			end
			S_PWR: begin
				if (ent_q.prv != NIL) begin
					e_we = 1'b1; e_addr = AW'(ent_q.prv);
					e_wd = e_rd; e_wd.nxt = ent_q.nxt;
				end
			end
			S_NRD: e_addr = AW'(ent_q.nxt);
			S_NWR: begin
				if (ent_q.nxt != NIL) begin
					e_we = 1'b1; e_addr = AW'(ent_q.nxt);
					e_wd = e_rd; e_wd.prv = ent_q.prv;
				end
			end
			S_CLR: begin
				e_we = 1'b1; e_addr = AW'(cur_q);
				e_wd.nxt = NIL; e_wd.prv = NIL;
			end
			S_WALK: e_addr = AW'(cur_q);
			S_WALKRD: begin
				if (cmd_q == CMD_KILL && hit) begin
					e_we = 1'b1; e_addr = AW'(cur_q);
					e_wd = e_rd; e_wd.dead = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			init_q   <= '0;
			top_q    <= NIL;
			least_q  <= NIL;
			ovalid_q <= 1'b0;
			out_q    <= '0;
			for (int i = 0; i < LIST_COUNT; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			state_q <= state_d;
			if (out_go) begin
				out_q    <= {4'd0, 9'(least_q), 9'(top_q), found_q, stat_q};
				ovalid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: init_q <= init_q + AW'(1);
				S_ALLOC: begin
					top_q <= top_q - PW'(1);
					if (least_q > top_q - PW'(1)) least_q <= top_q - PW'(1);
					if (head_q[li] == NIL) head_q[li] <= PW'(f_rd);
					tail_q[li] <= PW'(f_rd);
				end
				S_REL: begin
					if (ent_q.prv == NIL) head_q[own_safe] <= ent_q.nxt;
					if (ent_q.nxt == NIL) tail_q[own_safe] <= ent_q.prv;
					if (top_q < NIL) top_q <= top_q + PW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q   <= s_axis_tdata[2:0];
			lst_q   <= s_axis_tdata[5:3];
			slot_q  <= s_axis_tdata[13:6];
			id_q    <= s_axis_tdata[22:14];
			all_q   <= s_axis_tdata[23];
			back_q  <= s_axis_tuser;
			stat_q  <= ST_FAIL;
			found_q <= '0;
		end
		case (state_q)
			S_RD: begin
				guard_q <= '0;
				case (cmd_q)
					CMD_ALLOC:  cur_q <= tail_q[li];
					CMD_FREE:   cur_q <= PW'(slot_q);
					CMD_SEARCH: cur_q <= back_q ? tail_q[li] : head_q[li];
					default:    cur_q <= head_q[li];
				endcase
				if ((cmd_q == CMD_KILL || cmd_q == CMD_CLEAR) && list_ok) stat_q <= ST_OK;
			end
			S_ALLOC: begin
				q_q <= f_rd; stat_q <= ST_OK; found_q <= 8'(f_rd);
				ent_q <= e_rd;
			end
			S_FREE: begin
				if (slot_ok && e_rd.used) begin
					ent_q <= e_rd;
					stat_q <= ST_OK; found_q <= slot_q;
				end else stat_q <= ST_UNUSED;
			end
			S_WALKRD: begin
				guard_q <= guard_q + PW'(1);
				if (cmd_q == CMD_SEARCH && e_rd.id == id_q) begin
					stat_q <= ST_OK; found_q <= 8'(cur_q);
				end else if (cmd_q == CMD_CLEAR && hit) begin
					ent_q <= e_rd;
				end else begin
					cur_q <= (cmd_q == CMD_SEARCH && back_q) ? e_rd.prv : e_rd.nxt;
				end
			end
			// The walk resumes at the successor that the unlinked entry had.
			S_CLR: if (cmd_q == CMD_CLEAR) cur_q <= ent_q.nxt;
			default: ;
		endcase
	end
endmodule

[tb/tb_top.sv]
// Self-checking bench for the pooled linked-list manager core: random and directed commands.
// It depends on pllm_pkg and the pooled_linked_list_manager_core RTL.
`timescale 1ns / 1ps
module tb_top;
	import pllm_pkg::*;

	localparam int NSLOT = 256;
	localparam int NLIST = 8;
	localparam int NILV = NSLOT;
	localparam int STALL_MAX = 18;
	localparam int DRAIN_AT = 600;
	localparam int N_RANDOM = 466;
	localparam logic [2:0] CMD_UNK_LO = 3'd5;
	localparam logic [2:0] CMD_UNK_HI = 3'd7;
	localparam longint CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic       from_tail;
		logic       match_all;
		logic [8:0] effect_id;
		logic [7:0] slot;
		logic [2:0] list_sel;
		logic [2:0] command;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] found_slot;
		logic [8:0] free_count;
		logic [8:0] low_water;
	} rsp_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata;

	pooled_linked_list_manager_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Shadow copy of the pool state.
	int stk[NSLOT];
	int top_cnt, low_mark;
	int head[NLIST], tail[NLIST];
	int nxt[NSLOT], prv[NSLOT];
	int owner[NSLOT], ids[NSLOT];
	bit dead[NSLOT], used[NSLOT];

	cmd_t pending_cmds[$];
	rsp_t expected_rsps[$];
	int mismatches = 0;
	bit all_sent = 0;
	longint cycles = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic void pool_reset();
		for (int i = 0; i < NSLOT; i++) begin
			stk[i] = NSLOT - 1 - i;
			nxt[i] = NILV; prv[i] = NILV;
			owner[i] = 0; ids[i] = 0; dead[i] = 0; used[i] = 0;
		end
		for (int i = 0; i < NLIST; i++) begin
			head[i] = NILV; tail[i] = NILV;
		end
		top_cnt = NSLOT;
		low_mark = NSLOT;
	endfunction

	function automatic void unlink_and_free(int s);
		int l, p, n;
		l = owner[s]; p = prv[s]; n = nxt[s];
		if (p < NILV) nxt[p] = n; else head[l] = n;
		if (n < NILV) prv[n] = p; else tail[l] = p;
		nxt[s] = NILV; prv[s] = NILV;
		owner[s] = 0; ids[s] = 0; dead[s] = 0; used[s] = 0;
		if (top_cnt < NSLOT) begin
			stk[top_cnt] = s;
			top_cnt++;
		end
	endfunction

	function automatic rsp_t pool_apply(cmd_t c);
		rsp_t r;
		int a, n, q, g;
		bit ok;
		r.status = ST_FAIL;
		r.found_slot = 0;
		ok = c.list_sel < NLIST;
		if (c.command == CMD_ALLOC && ok) begin
			if (top_cnt >= 1) begin
				top_cnt--;
				q = stk[top_cnt];
				if (head[c.list_sel] >= NILV) begin
					head[c.list_sel] = q;
					prv[q] = NILV;
				end else begin
					nxt[tail[c.list_sel]] = q;
					prv[q] = tail[c.list_sel];
				end
				tail[c.list_sel] = q;
				nxt[q] = NILV;
				owner[q] = int'(c.list_sel); ids[q] = int'(c.effect_id);
				dead[q] = 0; used[q] = 1;
				if (low_mark > top_cnt) low_mark = top_cnt;
				r.status = ST_OK;
				r.found_slot = 8'(q);
			end
		end else if (c.command == CMD_FREE) begin
			if (used[c.slot]) begin
				unlink_and_free(int'(c.slot));
				r.status = ST_OK;
				r.found_slot = c.slot;
			end else begin
				r.status = ST_UNUSED;
			end
		end else if (c.command == CMD_SEARCH && ok) begin
			a = c.from_tail ? tail[c.list_sel] : head[c.list_sel];
			for (g = 0; a < NILV && g < NSLOT; g++) begin
				if (ids[a] == c.effect_id) break;
				a = c.from_tail ? prv[a] : nxt[a];
			end
			if (a < NILV && ids[a] == c.effect_id) begin
				r.status = ST_OK;
				r.found_slot = 8'(a);
			end
		end else if (c.command == CMD_KILL && ok) begin
			a = head[c.list_sel];
			for (g = 0; a < NILV && g < NSLOT; g++) begin
				if (c.match_all || ids[a] == c.effect_id) dead[a] = 1;
				a = nxt[a];
			end
			r.status = ST_OK;
		end else if (c.command == CMD_CLEAR && ok) begin
			a = head[c.list_sel];
			for (g = 0; a < NILV && g < NSLOT; g++) begin
				n = nxt[a];
				if (c.match_all || ids[a] == c.effect_id) unlink_and_free(a);
				a = n;
			end
			r.status = ST_OK;
		end
		r.free_count = 9'(top_cnt);
		r.low_water = 9'(low_mark);
		return r;
	endfunction

	function automatic cmd_t mk(logic [2:0] op, int l, int s, int id, bit all, bit bk);
		cmd_t c;
		c.command = op; c.list_sel = 3'(l); c.slot = 8'(s);
		c.effect_id = 9'(id); c.match_all = all; c.from_tail = bk;
		return c;
	endfunction

	// Mostly valid commands on a small id range so searches and clears hit.
	function automatic cmd_t rand_cmd();
		int k;
		cmd_t c;
		k = $urandom_range(0, 99);
		c = mk(CMD_ALLOC, $urandom_range(0, 7), $urandom_range(0, 255),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 7),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if (k < 45) c.command = CMD_ALLOC;
		else if (k < 70) c.command = CMD_FREE;
		else if (k < 82) c.command = CMD_SEARCH;
		else if (k < 88) c.command = CMD_KILL;
		else if (k < 95) c.command = CMD_CLEAR;
		else c.command = 3'($urandom_range(CMD_UNK_LO, CMD_UNK_HI));
		if (c.command == CMD_CLEAR && $urandom_range(0, 3) != 0) c.match_all = 0;
		return c;
	endfunction

	initial begin
		pending_cmds.push_back(mk(CMD_FREE, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_SEARCH, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ALLOC, 0, 0, 511, 0, 0));
		pending_cmds.push_back(mk(CMD_ALLOC, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_ALLOC, 7, 0, 5, 0, 0));
		pending_cmds.push_back(mk(CMD_ALLOC, 0, 0, 5, 0, 0));
		pending_cmds.push_back(mk(CMD_SEARCH, 0, 0, 5, 1, 1));
		pending_cmds.push_back(mk(CMD_SEARCH, 0, 0, 511, 0, 0));
		pending_cmds.push_back(mk(CMD_SEARCH, 7, 0, 6, 0, 1));
		pending_cmds.push_back(mk(CMD_KILL, 0, 0, 5, 0, 0));
		pending_cmds.push_back(mk(CMD_SEARCH, 0, 0, 5, 0, 0));
		pending_cmds.push_back(mk(CMD_FREE, 0, 1, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_FREE, 0, 1, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_FREE, 0, 255, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_UNK_LO, 0, 0, 0, 0, 0));
		pending_cmds.push_back(mk(CMD_UNK_HI, 7, 255, 511, 1, 1));
		pending_cmds.push_back(mk(CMD_KILL, 7, 0, 0, 1, 0));
		pending_cmds.push_back(mk(CMD_CLEAR, 0, 0, 0, 1, 0));
		pending_cmds.push_back(mk(CMD_CLEAR, 7, 0, 511, 0, 0));
		// Drain the pool to empty, then allocate into the empty pool.
		for (int i = 0; i < 257; i++)
			pending_cmds.push_back(mk(CMD_ALLOC, i % 8, 0, i % 4, 0, 0));
		for (int i = 0; i < 8; i++)
			pending_cmds.push_back(mk(CMD_CLEAR, i, 0, i % 4, 1'(i % 2), 0));
		for (int i = 0; i < N_RANDOM; i++)
			pending_cmds.push_back(rand_cmd());
	end

	// Stimulus side: each transaction draws its idle gap; one pause drains the block.
	int gap = 0;
	int sent = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 0;
			gap <= $urandom_range(0, STALL_MAX);
		end else begin
			if (s_axis_tvalid && !s_axis_tready) begin
				// Hold the transaction until it is taken.
			end else if (gap > 0) begin
				s_axis_tvalid <= 0;
				gap <= gap - 1;
			end else if (pending_cmds.size() == 0) begin
				s_axis_tvalid <= 0;
				all_sent <= 1;
			end else if (sent == DRAIN_AT && expected_rsps.size() != 0) begin
				s_axis_tvalid <= 0;
			end else begin
				cmd_t c;
				c = pending_cmds.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tdata <= c[23:0];
				s_axis_tuser <= c.from_tail;
				expected_rsps.push_back(pool_apply(c));
				sent <= sent + 1;
				gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, STALL_MAX);
			end
		end
	end

	// Response side: random backpressure and field checks.
	int rgap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			rgap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				rsp_t got, want;
				int r;
				got.status = m_axis_tdata[1:0];
				got.found_slot = m_axis_tdata[9:2];
				got.free_count = m_axis_tdata[18:10];
				got.low_water = m_axis_tdata[27:19];
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: %h", m_axis_tdata);
				end else begin
					want = expected_rsps.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected st=%0d slot=%0d free=%0d low=%0d,",
								" got st=%0d slot=%0d free=%0d low=%0d"},
								want.status, want.found_slot, want.free_count,
								want.low_water, got.status, got.found_slot,
								got.free_count, got.low_water);
					end
				end
				r = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, STALL_MAX);
				m_axis_tready <= (r == 0);
				rgap <= (r > 0) ? r - 1 : 0;
			end else if (rgap > 0) begin
				rgap <= rgap - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	initial begin
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		pool_reset();
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
			if (all_sent && expected_rsps.size() == 0) begin
				repeat (50) @(posedge clk);
				if (mismatches == 0 && expected_rsps.size() == 0)
					$display("status: pass");
				else
					$display("status: fail");
				$finish;
			end
		end
	end
endmodule
